>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on aclk and off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define RSQP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RSQP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/rsqp_pkg.sv
// ----------------------------------------------------------------------------
// rsqp_pkg
// Types and constants for the reciprocal square root pipeline.
// ----------------------------------------------------------------------------
package rsqp_pkg;

    localparam int FRAC_BITS_DEF = 56;
    localparam int NUM_COEF      = 6;
    localparam int CFG_IDX_W     = 3;

    localparam logic [63:0] SQRT_HALF_Q64 = 64'hB504F333F9DE6484;
    localparam logic [63:0] S64_MAX       = 64'h7FFFFFFFFFFFFFFF;
    localparam logic [63:0] S64_MIN       = 64'h8000000000000000;

    // payload that travels alongside the arithmetic
    typedef struct packed {
        logic signed [63:0] x;
        logic signed [63:0] s;
        logic [10:0]        ex;
        logic               bad;
        logic               be;
    } pipe_t;

    // saturate a 65-bit signed sum to the signed 64-bit range
    function automatic logic [63:0] sat65(input logic [64:0] v);
        logic [63:0] r;
        if (v[64] != v[63]) begin
            r = v[64] ? S64_MIN : S64_MAX;
        end else begin
            r = v[63:0];
        end
        return r;
    endfunction

endpackage

>>> design/rsqp_mul_cell.sv
// ----------------------------------------------------------------------------
// rsqp_mul_cell
// Two-stage fixed-point multiply, round, saturate, then saturating add.
// ----------------------------------------------------------------------------
module rsqp_mul_cell #(
    parameter int FRAC_BITS = rsqp_pkg::FRAC_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic signed [63:0]  a,
    input  logic signed [63:0]  b,
    input  logic signed [63:0]  addend,
    input  rsqp_pkg::pipe_t     pl_in,
    output logic                out_valid,
    output logic signed [63:0]  y,
    output rsqp_pkg::pipe_t     pl_out
);

    logic [63:0] ua, ub;
    logic [63:0] p00_reg, p01_reg, p10_reg, p11_reg;
    logic        neg_reg, va_reg, vb_reg;
    logic signed [63:0] add_reg, y_reg;
    rsqp_pkg::pipe_t pl_a_reg, pl_b_reg;

    logic [127:0] prod, shr;
    logic [63:0]  sm;
    logic [63:0]  y_next;

    assign ua = a[63] ? (~a + 64'd1) : a;
    assign ub = b[63] ? (~b + 64'd1) : b;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end else if (en) begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p00_reg  <= ua[31:0]  * ub[31:0];
            p01_reg  <= ua[31:0]  * ub[63:32];
            p10_reg  <= ua[63:32] * ub[31:0];
            p11_reg  <= ua[63:32] * ub[63:32];
            neg_reg  <= a[63] ^ b[63];
            add_reg  <= addend;
            pl_a_reg <= pl_in;
            y_reg    <= y_next;
            pl_b_reg <= pl_a_reg;
        end
    end

    always_comb begin
        prod = {64'd0, p00_reg} + ({64'd0, p01_reg} << 32) + ({64'd0, p10_reg} << 32)
             + {p11_reg, 64'd0};
        if (neg_reg) begin
            prod = ~prod + 128'd1;
        end
        prod = prod + (128'd1 << (FRAC_BITS - 1));
        shr  = 128'($signed(prod) >>> FRAC_BITS);
        if ((&shr[127:63]) || !(|shr[127:63])) begin
            sm = shr[63:0];
        end else begin
            sm = prod[127] ? rsqp_pkg::S64_MIN : rsqp_pkg::S64_MAX;
        end
        y_next = rsqp_pkg::sat65({add_reg[63], add_reg} + {sm[63], sm});
    end

    assign out_valid = vb_reg;
    assign y         = y_reg;
    assign pl_out    = pl_b_reg;

endmodule

>>> design/rsqp_pack.sv
// ----------------------------------------------------------------------------
// rsqp_pack
// Odd-exponent scaling, normalization and IEEE double packing.
// ----------------------------------------------------------------------------
module rsqp_pack #(
    parameter int FRAC_BITS = rsqp_pkg::FRAC_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  logic signed [63:0] s_in,
    input  rsqp_pkg::pipe_t    pl_in,
    output logic               out_valid,
    output logic [63:0]        result,
    output logic               invalid,
    output logic               last
);

    logic        v1_reg, v2_reg, v3_reg, v4_reg;
    logic [63:0] p00_reg, p01_reg, p10_reg, p11_reg, s1_reg;
    logic        odd1_reg, np1_reg, bad1_reg, be1_reg;
    logic signed [11:0] q1_reg, q2_reg, q3_reg;
    logic [63:0] m2_reg, m3_reg;
    logic        zero2_reg, zero3_reg, bad2_reg, be2_reg, bad3_reg, be3_reg;
    logic [5:0]  p3_reg;
    logic [63:0] res_reg, res_next;
    logic        inv_reg, last_reg;

    logic        odd;
    logic signed [11:0] k_adj;
    logic signed [11:0] q_next;
    logic [127:0] sum;
    logic [63:0]  m_next;
    logic [5:0]   p_next;
    logic [63:0]  mm;
    logic [5:0]   sh;
    logic signed [13:0] e_val;

    assign odd = !pl_in.ex[0];

    always_comb begin
        k_adj  = 12'({1'b0, pl_in.ex}) - 12'd1023 - {11'd0, odd};
        q_next = k_adj >>> 1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_comb begin
        sum = {64'd0, p00_reg} + ({64'd0, p01_reg} << 32) + ({64'd0, p10_reg} << 32)
            + {p11_reg, 64'd0};
        m_next = odd1_reg ? (sum[127:64] + {63'd0, sum[63]}) : s1_reg;
    end

    // highest set bit of the magnitude
    always_comb begin
        p_next = 6'd0;
        for (int i = 0; i < 64; i++) begin
            if (m2_reg[i]) begin
                p_next = 6'(i);
            end
        end
    end

    always_comb begin
        mm    = 64'd0;
        sh    = 6'd0;
        e_val = 14'($signed({8'd0, p3_reg})) - 14'(FRAC_BITS) - 14'(q3_reg) + 14'sd1023;
        if (p3_reg > 6'd52) begin
            sh = p3_reg - 6'd52;
            mm = (m3_reg >> sh) + ((m3_reg >> (sh - 6'd1)) & 64'd1);
            if (mm[53]) begin
                mm    = mm >> 1;
                e_val = e_val + 14'sd1;
            end
        end else begin
            mm = m3_reg << (6'd52 - p3_reg);
        end
        res_next = {1'b0, e_val[10:0], mm[51:0]};
        if (bad3_reg || zero3_reg) begin
            res_next = 64'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p00_reg  <= s_in[31:0]  * rsqp_pkg::SQRT_HALF_Q64[31:0];
            p01_reg  <= s_in[31:0]  * rsqp_pkg::SQRT_HALF_Q64[63:32];
            p10_reg  <= s_in[63:32] * rsqp_pkg::SQRT_HALF_Q64[31:0];
            p11_reg  <= s_in[63:32] * rsqp_pkg::SQRT_HALF_Q64[63:32];
            s1_reg   <= s_in;
            odd1_reg <= odd;
            np1_reg  <= (s_in <= 64'sd0);
            bad1_reg <= pl_in.bad;
            be1_reg  <= pl_in.be;
            q1_reg   <= q_next;

            m2_reg    <= m_next;
            zero2_reg <= np1_reg || (m_next == 64'd0);
            bad2_reg  <= bad1_reg;
            be2_reg   <= be1_reg;
            q2_reg    <= q1_reg;

            m3_reg    <= m2_reg;
            p3_reg    <= p_next;
            zero3_reg <= zero2_reg;
            bad3_reg  <= bad2_reg;
            be3_reg   <= be2_reg;
            q3_reg    <= q2_reg;

            res_reg  <= res_next;
            inv_reg  <= bad3_reg;
            last_reg <= be3_reg;
        end
    end

    // the result of a non-positive or vanished estimate is sent as zero
    assign out_valid = v4_reg;
    assign result    = res_reg;
    assign invalid   = inv_reg;
    assign last      = last_reg;

endmodule

>>> design/reciprocal_sqrt_poly_newton.sv
// ----------------------------------------------------------------------------
// reciprocal_sqrt_poly_newton
// Pipeline: eight two-stage multiply cells, one subtract stage, four
//   packing stages.
// Throughput: one transaction per cycle; the whole pipe holds when the
//   output register is full and not taken.
// Reset: aresetn clears all valid bits and the six coefficients to zero.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module reciprocal_sqrt_poly_newton #(
    parameter int FRAC_BITS = rsqp_pkg::FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [63:0] operand_bits
    input  logic        s_tlast,   // batch_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [63:0] result_bits
    output logic        m_tuser,   // invalid
    output logic        m_tlast,   // batch_end_out
    input  logic        cfg_we,
    input  logic [rsqp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0] cfg_wdata
);

    localparam logic [63:0] C15 = 64'd3 << (FRAC_BITS - 1);

    logic signed [63:0] coef_reg [rsqp_pkg::NUM_COEF];
    logic en;

    logic [51:0] frac;
    logic [10:0] ex;
    logic [63:0] mant;
    rsqp_pkg::pipe_t pl0;

    logic               hv  [6];
    logic signed [63:0] hy  [6];
    rsqp_pkg::pipe_t    hpl [6];

    rsqp_pkg::pipe_t    pl_t1_in;
    logic               t1_v, t2_v, fin_v, h_v_reg;
    logic signed [63:0] t1_y, t2_y, fin_y, h_reg, tt;
    rsqp_pkg::pipe_t    t1_pl, t2_pl, h_pl_reg, fin_pl;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < rsqp_pkg::NUM_COEF; i++) begin
                coef_reg[i] <= 64'sd0;
            end
        end else if (cfg_we && (cfg_index < rsqp_pkg::CFG_IDX_W'(rsqp_pkg::NUM_COEF))) begin
            coef_reg[cfg_index] <= cfg_wdata;
        end
    end

    always_comb begin
        ex   = s_tdata[62:52];
        frac = s_tdata[51:0];
        if (FRAC_BITS >= 52) begin
            mant = {12'd0, frac} << ((FRAC_BITS >= 52) ? (FRAC_BITS - 52) : 0);
        end else begin
            mant = {12'd0, frac} >> ((FRAC_BITS < 52) ? (52 - FRAC_BITS) : 0);
        end
        pl0.x   = (64'd1 << FRAC_BITS) | mant;
        pl0.s   = 64'sd0;
        pl0.ex  = ex;
        pl0.bad = s_tdata[63] || (ex == 11'd0) || (&ex);
        pl0.be  = s_tlast;
    end

    // Horner chain, coefficient five down to zero
    for (genvar i = 0; i < 5; i++) begin : g_horner
        if (i == 0) begin : g_first
            rsqp_mul_cell #(.FRAC_BITS(FRAC_BITS)) u_cell (
                .aclk(aclk), .aresetn(aresetn), .en(en),
                .in_valid(s_tvalid && s_tready), .a(pl0.x), .b(coef_reg[5]),
                .addend(coef_reg[4]), .pl_in(pl0),
                .out_valid(hv[i]), .y(hy[i]), .pl_out(hpl[i])
            );
        end else begin : g_next
            rsqp_mul_cell #(.FRAC_BITS(FRAC_BITS)) u_cell (
                .aclk(aclk), .aresetn(aresetn), .en(en),
                .in_valid(hv[i-1]), .a(hpl[i-1].x), .b(hy[i-1]),
                .addend(coef_reg[4-i]), .pl_in(hpl[i-1]),
                .out_valid(hv[i]), .y(hy[i]), .pl_out(hpl[i])
            );
        end
    end

    always_comb begin
        pl_t1_in   = hpl[4];
        pl_t1_in.s = hy[4];
    end

    rsqp_mul_cell #(.FRAC_BITS(FRAC_BITS)) u_t1 (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(hv[4]), .a(pl_t1_in.x), .b(hy[4]), .addend(64'sd0),
        .pl_in(pl_t1_in), .out_valid(t1_v), .y(t1_y), .pl_out(t1_pl)
    );

    rsqp_mul_cell #(.FRAC_BITS(FRAC_BITS)) u_t2 (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(t1_v), .a(t1_y), .b(t1_pl.s), .addend(64'sd0),
        .pl_in(t1_pl), .out_valid(t2_v), .y(t2_y), .pl_out(t2_pl)
    );

    // h = 1.5 - t/2, saturating
    assign tt = t2_y >>> 1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h_v_reg <= 1'b0;
        end else if (en) begin
            h_v_reg <= t2_v;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            h_reg    <= rsqp_pkg::sat65({C15[63], C15} - {tt[63], tt});
            h_pl_reg <= t2_pl;
        end
    end

    rsqp_mul_cell #(.FRAC_BITS(FRAC_BITS)) u_fin (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(h_v_reg), .a(h_pl_reg.s), .b(h_reg), .addend(64'sd0),
        .pl_in(h_pl_reg), .out_valid(fin_v), .y(fin_y), .pl_out(fin_pl)
    );

    rsqp_pack #(.FRAC_BITS(FRAC_BITS)) u_pack (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(fin_v), .s_in(fin_y), .pl_in(fin_pl),
        .out_valid(m_tvalid), .result(m_tdata), .invalid(m_tuser), .last(m_tlast)
    );

    `RSQP_ASSERT_NOW(a_inv_zero, m_tvalid && m_tuser, m_tdata == 64'd0, "invalid result not zero")
    `RSQP_ASSERT_NOW(a_sign_clr, m_tvalid, !m_tdata[63], "result sign set")
    `RSQP_ASSERT_NOW(a_stall_in, m_tvalid && !m_tready, !s_tready, "input taken while stalled")

endmodule
